// ===== rtl/efa_pkg.sv =====
// shared types and constants for the extended float adder
package efa_pkg;

  localparam int unsigned MANT_W = 64;
  localparam int unsigned WORD_W = 16;
  localparam int unsigned EXP_W  = 15;
  localparam int unsigned LZC_W  = 7;

  typedef struct packed {
    logic [MANT_W-1:0] first_mantissa;
    logic [WORD_W-1:0] first_sign_exp;
    logic [MANT_W-1:0] second_mantissa;
    logic [WORD_W-1:0] second_sign_exp;
  } in_req_t;

  typedef struct packed {
    logic [MANT_W-1:0] sum_mantissa;
    logic [WORD_W-1:0] sum_sign_exp;
  } out_req_t;

endpackage

// ===== rtl/efa_norm.sv =====
// normalization stages: leading zero count then left shift
module efa_norm (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           vld_i,
  input  logic                           pass_i,
  input  logic [efa_pkg::MANT_W-1:0]     mag_i,
  input  logic [efa_pkg::WORD_W-1:0]     word_i,
  output logic                           vld_o,
  output efa_pkg::out_req_t              res_o
);

  logic                          vld_r;
  logic                          pass_r;
  logic [efa_pkg::MANT_W-1:0]    mag_r;
  logic [efa_pkg::WORD_W-1:0]    word_r;
  logic [efa_pkg::LZC_W-1:0]     lz_nxt;
  logic [efa_pkg::LZC_W-1:0]     lz_r;
  logic                          out_vld_r;
  efa_pkg::out_req_t             res_nxt;
  efa_pkg::out_req_t             res_r;

  // leading zero count of the magnitude
  always_comb begin
    lz_nxt = efa_pkg::LZC_W'(0);
    for (int i = 0; i < efa_pkg::MANT_W; i++) begin
      if (mag_i[i]) begin
        lz_nxt = efa_pkg::LZC_W'(efa_pkg::MANT_W - 1 - i);
      end
    end
  end

  // stage: count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
    pass_r <= pass_i;
    mag_r  <= mag_i;
    word_r <= word_i;
    lz_r   <= lz_nxt;
  end

  // shift and exponent decrement, bypassed for pass-through and zero
  always_comb begin
    if (pass_r || mag_r == '0) begin
      res_nxt.sum_mantissa = mag_r;
      res_nxt.sum_sign_exp = word_r;
    end else begin
      res_nxt.sum_mantissa = mag_r << lz_r;
      res_nxt.sum_sign_exp = word_r - efa_pkg::WORD_W'(lz_r);
    end
  end

  // stage: shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= vld_r;
    end
    res_r <= res_nxt;
  end

  assign vld_o = out_vld_r;
  assign res_o = res_r;

endmodule

// ===== rtl/extended_float_add.sv =====
// top level of the pipelined extended float adder
//
// channel | ports                       | direction | timing
// input   | start, busy, in_req         | in        | taken when start && !busy
// result  | out_valid, out_req          | out       | one cycle strobe, no stall
//
// one add enters per cycle; each result is registered in every stage below before it appears
// stages: compare/align, signed add, complement, leading zero count, shift
// busy stays low: the receiver cannot stall, so nothing backs up
// reset clears the valid bits of all stages; payload registers are not reset
module extended_float_add (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  efa_pkg::in_req_t   in_req,
  output logic               out_valid,
  output efa_pkg::out_req_t  out_req
);

  localparam int unsigned MW = efa_pkg::MANT_W;
  localparam int unsigned WW = efa_pkg::WORD_W;
  localparam int unsigned EW = efa_pkg::EXP_W;

  logic [EW-1:0] x1, x2, gap;
  logic          first_big;
  logic [MW-1:0] big_m, small_m;
  logic [WW-1:0] big_w, small_w;

  // stage 1 registers
  logic          s1_vld_r, s1_pass_r;
  logic [MW-1:0] s1_a_r, s1_b_r, s1_big_m_r;
  logic [WW-1:0] s1_w_r;

  // stage 2 registers
  logic          s2_vld_r, s2_pass_r;
  logic [MW-1:0] s2_sum_r;
  logic [WW-1:0] s2_w_r;

  logic [MW-1:0] mag_nxt;
  logic [WW-1:0] wd_nxt;
  logic          s3_vld_r, s3_pass_r;
  logic [MW-1:0] s3_mag_r;
  logic [WW-1:0] s3_w_r;

  assign busy = 1'b0;

  // pick the base operand and align the other
  always_comb begin
    x1        = in_req.first_sign_exp[EW-1:0];
    x2        = in_req.second_sign_exp[EW-1:0];
    first_big = x1 > x2;
    big_m     = first_big ? in_req.first_mantissa  : in_req.second_mantissa;
    big_w     = first_big ? in_req.first_sign_exp  : in_req.second_sign_exp;
    small_m   = first_big ? in_req.second_mantissa : in_req.first_mantissa;
    small_w   = first_big ? in_req.second_sign_exp : in_req.first_sign_exp;
    gap       = first_big ? x1 - x2 : x2 - x1;
  end

  // stage 1: aligned and signed operands
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start;
    end
    s1_pass_r  <= gap >= EW'(MW);
    s1_big_m_r <= big_m;
    s1_a_r     <= big_w[WW-1] ? -(big_m >> 2) : (big_m >> 2);
    s1_b_r     <= small_w[WW-1] ? -((small_m >> gap[5:0]) >> 2) : ((small_m >> gap[5:0]) >> 2);
    s1_w_r     <= big_w;
  end

  // stage 2: the add, word gets the raised exponent unless passed through
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_pass_r <= s1_pass_r;
    s2_sum_r  <= s1_pass_r ? s1_big_m_r : s1_a_r + s1_b_r;
    s2_w_r    <= s1_pass_r ? s1_w_r : {1'b0, s1_w_r[EW-1:0] + EW'(2)};
  end

  // back to sign-magnitude
  always_comb begin
    mag_nxt = s2_sum_r;
    wd_nxt  = s2_w_r;
    if (!s2_pass_r) begin
      if (s2_sum_r == '0) begin
        wd_nxt = '0;
      end else if (s2_sum_r[MW-1]) begin
        mag_nxt    = -s2_sum_r;
        wd_nxt[WW-1] = 1'b1;
      end
    end
  end

  // stage 3: magnitude
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
    s3_pass_r <= s2_pass_r;
    s3_mag_r  <= mag_nxt;
    s3_w_r    <= wd_nxt;
  end

  // stages 4 and 5: normalize
  efa_norm u_norm (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (s3_vld_r),
    .pass_i (s3_pass_r),
    .mag_i  (s3_mag_r),
    .word_i (s3_w_r),
    .vld_o  (out_valid),
    .res_o  (out_req)
  );

endmodule

// ===== rtl/efa_checker.sv =====
// port checker for the extended float adder
module efa_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input efa_pkg::out_req_t out_req,
  input logic              out_valid
);

  // never stalls
  a_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  // each accepted request brings out a result
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##5 out_valid)
    else $error("result missing");

  // no result without a request
  a_nofake: assert property (@(posedge clk) disable iff (!rst_n)
    (!$past(start, 5) && $past(rst_n, 5)) |-> !out_valid)
    else $error("unexpected result");

  // a strobed result carries known bits
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown(out_req))
    else $error("unknown result bits");

endmodule

bind extended_float_add efa_checker u_efa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_req   (out_req),
  .out_valid (out_valid)
);

// ===== tb/efa_checker.sv =====
// checker for the extended float adder: predicts each sum and compares results
`timescale 1ns / 1ps
module efa_scoreboard (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  efa_pkg::in_req_t   in_req,
  input  logic               out_valid,
  input  efa_pkg::out_req_t  out_req,
  output int                 fail_count,
  output int                 pending,
  output int                 sums_seen
);

  localparam logic [15:0] SIGN_BIT = 16'h8000;
  localparam logic [14:0] EXP_MASK = 15'h7fff;

  efa_pkg::out_req_t sum_queue[$];

  // shift to 62 bits and negate when the sign is set
  function automatic logic [63:0] to_signed62(logic [63:0] mant, logic [15:0] word);
    logic [63:0] m;
    m = mant >> 2;
    if (word[15]) m = ~m + 64'd1;
    return m;
  endfunction

  // predicted sum of one request
  function automatic efa_pkg::out_req_t predict_sum(efa_pkg::in_req_t r);
    efa_pkg::out_req_t res;
    logic [63:0] big_m, small_m, acc;
    logic [15:0] big_w, small_w, ew;
    int unsigned gap;
    if (r.first_sign_exp[14:0] > r.second_sign_exp[14:0]) begin
      big_m = r.first_mantissa;  big_w = r.first_sign_exp;
      small_m = r.second_mantissa; small_w = r.second_sign_exp;
    end else begin
      big_m = r.second_mantissa; big_w = r.second_sign_exp;
      small_m = r.first_mantissa;  small_w = r.first_sign_exp;
    end
    gap = big_w[14:0] - small_w[14:0];
    if (gap >= 64) begin
      res.sum_mantissa = big_m;
      res.sum_sign_exp = big_w;
      return res;
    end
    small_m = small_m >> gap;
    ew = {1'b0, (big_w[14:0] + 15'd2) & EXP_MASK};
    acc = to_signed62(big_m, big_w) + to_signed62(small_m, small_w);
    if (acc == 64'd0) begin
      res.sum_mantissa = '0;
      res.sum_sign_exp = '0;
      return res;
    end
    if (acc[63]) begin
      acc = ~acc + 64'd1;
      ew = ew | SIGN_BIT;
    end
    while (!acc[63]) begin
      ew = ew - 16'd1;
      acc = acc << 1;
    end
    res.sum_mantissa = acc;
    res.sum_sign_exp = ew;
    return res;
  endfunction

  // record requests and compare results
  always @(posedge clk) begin
    efa_pkg::out_req_t want;
    if (!rst_n) begin
      fail_count <= 0;
      sums_seen <= 0;
      pending <= 0;
    end else begin
      if (out_valid) begin
        sums_seen <= sums_seen + 1;
        if (sum_queue.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10)
            $display("unexpected result %h %h", out_req.sum_mantissa, out_req.sum_sign_exp);
        end else begin
          want = sum_queue.pop_front();
          if (want.sum_mantissa !== out_req.sum_mantissa ||
              want.sum_sign_exp !== out_req.sum_sign_exp) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: expected %h %h got %h %h", want.sum_mantissa,
                       want.sum_sign_exp, out_req.sum_mantissa, out_req.sum_sign_exp);
          end
        end
      end
      if (start && !busy) sum_queue.push_back(predict_sum(in_req));
      pending <= sum_queue.size();
    end
  end
endmodule

// ===== tb/testbench.sv =====
// testbench top: stimulus, idling phases and verdict for the extended float adder
`timescale 1ns / 1ps
module testbench;

  localparam int WATCHDOG = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy, out_valid;
  efa_pkg::in_req_t in_req = '0;
  efa_pkg::out_req_t out_req;
  int fail_count, pending, sums_seen;
  int idle_cycles = 0;
  int sent = 0;
  int idle_pct = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  extended_float_add dut (.*);
  efa_scoreboard chk (.*);

  // watchdog on cycles with no accepted request or result
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("timeout");
      $display("FAIL extended_float_add");
      $finish;
    end
  end

  function automatic logic [63:0] rand_mant();
    logic [63:0] m;
    m = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: m = '0;
      1: m = '1;
      2: m[63] = 1'b1;
      3: m = m >> $urandom_range(0, 63);
      default: m[63] = 1'b1;
    endcase
    return m;
  endfunction

  // exponent of the second operand near the first most of the time
  function automatic efa_pkg::in_req_t rand_add();
    efa_pkg::in_req_t r;
    logic [14:0] e;
    r.first_mantissa = rand_mant();
    r.second_mantissa = rand_mant();
    r.first_sign_exp = 16'($urandom);
    e = r.first_sign_exp[14:0];
    case ($urandom_range(0, 3))
      0: e = 15'($urandom);
      1: e = e;
      default: e = e + 15'($signed($urandom_range(0, 140)) - 70);
    endcase
    r.second_sign_exp = {1'($urandom), e};
    if ($urandom_range(0, 7) == 0) begin
      r.second_mantissa = r.first_mantissa;
      r.second_sign_exp = r.first_sign_exp ^ 16'h8000;
    end
    return r;
  endfunction

  // hand one request over, with random idling before it
  task automatic send(efa_pkg::in_req_t r);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  // stop sending and wait until every sum has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_add(logic [63:0] m1, logic [15:0] w1, logic [63:0] m2,
                          logic [15:0] w2);
    efa_pkg::in_req_t r;
    r = {m1, w1, m2, w2};
    send(r);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, ties, large gaps, cancellation, exponent wrap
    send_add('0, 16'h0000, '0, 16'h0000);
    send_add('1, 16'hffff, '1, 16'hffff);
    send_add('1, 16'h7fff, '1, 16'h7fff);
    send_add(64'h8000_0000_0000_0000, 16'h3fff, 64'h8000_0000_0000_0000, 16'h3fff);
    send_add(64'h8000_0000_0000_0000, 16'h3fff, 64'h8000_0000_0000_0000, 16'hbfff);
    send_add(64'hc000_0000_0000_0000, 16'h4000, 64'h8000_0000_0000_0000, 16'h3fff);
    send_add(64'h1234_5678_9abc_def0, 16'h4040, 64'hffff_0000_ffff_0000, 16'h4000);
    send_add(64'h1234_5678_9abc_def0, 16'h4000, 64'hffff_0000_ffff_0000, 16'hc040);
    send_add(64'h1234_5678_9abc_def0, 16'h403f, 64'hffff_0000_ffff_0000, 16'h4000);
    send_add(64'h8000_0000_0000_0001, 16'h0000, 64'h8000_0000_0000_0000, 16'h8000);
    send_add(64'h0000_0000_0000_0004, 16'h0001, 64'h0000_0000_0000_0000, 16'h0001);
    send_add(64'hffff_ffff_ffff_fffc, 16'hfffe, 64'hffff_ffff_ffff_fffc, 16'hfffe);
    send_add(64'hffff_ffff_ffff_fffc, 16'h7ffe, 64'hffff_ffff_ffff_fffc, 16'h7ffe);
    send_add(64'h8000_0000_0000_0000, 16'h7fff, 64'h1, 16'h0000);
    send_add(64'h5555_5555_5555_5555, 16'haaaa, 64'haaaa_aaaa_aaaa_aaaa, 16'h5555);
    send_add(64'h0000_0000_0000_0003, 16'h8005, 64'h0000_0000_0000_0003, 16'h0005);
    send_add(64'h0000_0000_0000_0010, 16'h0000, 64'h0000_0000_0000_0008, 16'h0000);

    // hold off until every sum has come back
    drain();

    // random phases: no idling, heavy idling twice, then light idling
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 0) ? 0 : (ph == 3) ? 28 : 73;
      repeat (110) send(rand_add());
    end

    drain();
    repeat (10) @(posedge clk);
    $display("sent %0d adds (directed and random, four idling phases), %0d sums checked",
             sent, sums_seen);
    if (fail_count == 0) $display("PASS extended_float_add");
    else $display("FAIL extended_float_add");
    $finish;
  end
endmodule
